@@ design/wfc_pkg.sv @@
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared types and constants of the word frequency counter.
// ----------------------------------------------------------------------------
package wfc_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int MAX_WORD_LEN  = 16;
   localparam int COUNT_BITS    = 24;

   localparam logic [1:0] ACT_BYTE  = 2'd0;
   localparam logic [1:0] ACT_FLUSH = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_D0    = 8'h30;
   localparam logic [7:0] CH_D9    = 8'h39;
   localparam logic [7:0] CASE_OFS = 8'd32;

   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_LEN,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_HIT,
      ST_MISS_COPY,
      ST_MISS_DONE,
      ST_RD_LEN,
      ST_RD_CHAR,
      ST_RD_EMIT
   } state_type;

   typedef struct packed {
      logic clr_entry;
      logic inc_entry;
      logic clr_pos;
      logic inc_pos;
      logic load_sel;
      logic append;
      logic rd_len;
      logic rd_char;
      logic rd_slen;
      logic rd_schar;
      logic count_write;
      logic new_entry;
      logic copy_char;
      logic clear_pending;
      logic emit_hit;
      logic emit_new;
      logic emit_drop;
      logic emit_char;
      logic emit_empty;
   } ctrl_type;

   typedef struct packed {
      logic is_sep;
      logic is_keep;
      logic pending_zero;
      logic entry_end;
      logic table_full;
      logic len_eq;
      logic char_eq;
      logic pos_end;
      logic sel_ok;
      logic rd_last;
   } stat_type;

endpackage

@@ design/word_frequency_counter_core.sv @@
// ----------------------------------------------------------------------------
// word_frequency_counter_core
// Word frequency counter: byte-wise word collection, table search and readout.
//
// channel  ports   transfer
// request  req_*   start && !busy
// response rsp_*   rsp_valid, one cycle, no backpressure
//
// Plain text bytes are taken while idle. Closing a word scans stored
// entries: each length is read and compared, and on equal length the
// characters are read and compared one by one; a hit then updates the
// count, an insert copies each character, then writes length and count.
// A readout reads length and count, then reads and emits each character.
// Results cannot stall and appear in the cycle after the deciding state.
// Synchronous reset empties the table via the entry count; no clearing pass.
// ----------------------------------------------------------------------------
module word_frequency_counter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_text_byte,
   input  logic [5:0]  req_entry_select,
   output logic        rsp_valid,
   output logic        rsp_result_kind,
   output logic [5:0]  rsp_entry_index,
   output logic [23:0] rsp_entry_count,
   output logic        rsp_is_new_word,
   output logic        rsp_word_dropped,
   output logic        rsp_truncated_seen,
   output logic        rsp_entry_valid,
   output logic [7:0]  rsp_out_char,
   output logic [3:0]  rsp_char_position,
   output logic [6:0]  rsp_entries_used,
   output logic        rsp_last
);
   import wfc_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   wfc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_action(req_action),
      .stat(stat), .ctrl(ctrl), .busy(busy)
   );

   wfc_dp u_dp (
      .clock(clock), .reset(reset),
      .req_text_byte(req_text_byte), .req_entry_select(req_entry_select),
      .ctrl(ctrl), .stat(stat), .rsp_valid(rsp_valid),
      .rsp_result_kind(rsp_result_kind), .rsp_entry_index(rsp_entry_index),
      .rsp_entry_count(rsp_entry_count), .rsp_is_new_word(rsp_is_new_word),
      .rsp_word_dropped(rsp_word_dropped), .rsp_truncated_seen(rsp_truncated_seen),
      .rsp_entry_valid(rsp_entry_valid), .rsp_out_char(rsp_out_char),
      .rsp_char_position(rsp_char_position), .rsp_entries_used(rsp_entries_used),
      .rsp_last(rsp_last)
   );

   a_new_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_new_word |-> rsp_entry_valid && rsp_entry_count == 24'd1)
      else $error("new word report malformed");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_dropped |-> rsp_entries_used == 7'(TABLE_ENTRIES))
      else $error("drop while table not full");
   a_trunc_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated_seen |=> !rsp_valid || rsp_truncated_seen)
      else $error("truncation flag cleared");
endmodule

@@ design/wfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// wfc_ctrl
// Sequencer: search, insert and readout control.
// ----------------------------------------------------------------------------
module wfc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_action,
   input  wfc_pkg::stat_type stat,
   output wfc_pkg::ctrl_type ctrl,
   output logic              busy
);
   import wfc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if ((req_action == ACT_BYTE && stat.is_sep) || req_action == ACT_FLUSH) begin
                  if (!stat.pending_zero) state_in = ST_SRCH_LEN;
               end else if (req_action == ACT_READ) begin
                  state_in = stat.sel_ok ? ST_RD_LEN : ST_IDLE;
               end
            end
         end
         ST_SRCH_LEN: begin
            if (stat.entry_end) state_in = stat.table_full ? ST_IDLE : ST_MISS_COPY;
            else state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD:   state_in = stat.len_eq ? ST_SRCH_CMP : ST_SRCH_LEN;
         ST_SRCH_CMP: begin
            if (!stat.char_eq) state_in = ST_SRCH_LEN;
            else if (stat.pos_end) state_in = ST_HIT;
            else state_in = ST_SRCH_RD;
         end
         ST_HIT:       state_in = ST_IDLE;
         ST_MISS_COPY: if (stat.pos_end) state_in = ST_MISS_DONE;
         ST_MISS_DONE: state_in = ST_IDLE;
         ST_RD_LEN:    state_in = ST_RD_CHAR;
         ST_RD_CHAR:   state_in = ST_RD_EMIT;
         ST_RD_EMIT:   state_in = stat.rd_last ? ST_IDLE : ST_RD_CHAR;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.clr_entry = 1'b1;
            ctrl.clr_pos   = 1'b1;
            ctrl.load_sel  = start && req_action == ACT_READ;
            ctrl.append    = start && req_action == ACT_BYTE && stat.is_keep;
            ctrl.emit_empty = start && req_action == ACT_READ && !stat.sel_ok;
         end
         ST_SRCH_LEN: begin
            ctrl.clr_pos = 1'b1;
            ctrl.rd_slen = !stat.entry_end;
            ctrl.emit_drop = stat.entry_end && stat.table_full;
            ctrl.clear_pending = stat.entry_end && stat.table_full;
         end
         ST_SRCH_RD: begin
            ctrl.rd_schar = 1'b1;
            ctrl.inc_entry = !stat.len_eq;
         end
         ST_SRCH_CMP: begin
            ctrl.inc_entry = !stat.char_eq;
            ctrl.inc_pos = stat.char_eq && !stat.pos_end;
         end
         ST_HIT: begin
            ctrl.count_write = 1'b1;
            ctrl.emit_hit = 1'b1;
            ctrl.clear_pending = 1'b1;
         end
         ST_MISS_COPY: begin
            ctrl.copy_char = 1'b1;
            ctrl.inc_pos = 1'b1;
         end
         ST_MISS_DONE: begin
            ctrl.new_entry = 1'b1;
            ctrl.emit_new = 1'b1;
            ctrl.clear_pending = 1'b1;
         end
         ST_RD_LEN:  ctrl.rd_len = 1'b1;
         ST_RD_CHAR: ctrl.rd_char = 1'b1;
         ST_RD_EMIT: begin
            ctrl.emit_char = 1'b1;
            ctrl.inc_pos = 1'b1;
         end
         default: ;
      endcase
   end
endmodule

@@ design/wfc_dp.sv @@
// ----------------------------------------------------------------------------
// wfc_dp
// Datapath: pending word, word table memories, counts and result register.
// ----------------------------------------------------------------------------
module wfc_dp (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_text_byte,
   input  logic [5:0]        req_entry_select,
   input  wfc_pkg::ctrl_type ctrl,
   output wfc_pkg::stat_type stat,
   output logic              rsp_valid,
   output logic              rsp_result_kind,
   output logic [5:0]        rsp_entry_index,
   output logic [23:0]       rsp_entry_count,
   output logic              rsp_is_new_word,
   output logic              rsp_word_dropped,
   output logic              rsp_truncated_seen,
   output logic              rsp_entry_valid,
   output logic [7:0]        rsp_out_char,
   output logic [3:0]        rsp_char_position,
   output logic [6:0]        rsp_entries_used,
   output logic              rsp_last
);
   import wfc_pkg::*;

   localparam int EB = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int UB = $clog2(TABLE_ENTRIES + 1);
   localparam int PB = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int LB = $clog2(MAX_WORD_LEN + 1);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   logic [7:0]            pend_mem [MAX_WORD_LEN];
   logic [7:0]            char_mem [TABLE_ENTRIES*(2**PB)];
   logic [LB-1:0]         len_mem  [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem  [TABLE_ENTRIES];

   logic [LB-1:0]         plen_ff, plen_in;
   logic [UB-1:0]         used_ff, used_in;
   logic                  trunc_ff, trunc_in;
   logic [UB-1:0]         ent_ff;
   logic [LB-1:0]         pos_ff;
   logic [EB-1:0]         sel_ff;
   logic [LB-1:0]         tlen_ff;
   logic [7:0]            tchar_ff;
   logic [COUNT_BITS-1:0] tcnt_ff;
   logic [COUNT_BITS-1:0] cinc;
   logic [PB-1:0]         pidx;
   logic [EB-1:0]         eidx;
   logic [7:0]            fold;

   assign pidx = pos_ff[PB-1:0];
   assign eidx = ent_ff[EB-1:0];
   assign fold = (req_text_byte >= CH_UA && req_text_byte <= CH_UZ) ?
                 req_text_byte + CASE_OFS : req_text_byte;
   assign cinc = (tcnt_ff < CMAX) ? tcnt_ff + COUNT_BITS'(1) : tcnt_ff;

   always_comb begin
      stat = '0;
      stat.is_sep = req_text_byte == CH_SPACE || req_text_byte == CH_TAB ||
                    req_text_byte == CH_LF;
      stat.is_keep = (fold >= CH_LA && fold <= CH_LZ) || (fold >= CH_D0 && fold <= CH_D9);
      stat.pending_zero = plen_ff == '0;
      stat.entry_end = ent_ff == used_ff;
      stat.table_full = used_ff == UB'(TABLE_ENTRIES);
      stat.len_eq = tlen_ff == plen_ff;
      stat.char_eq = tchar_ff == pend_mem[pidx];
      stat.pos_end = pos_ff + LB'(1) >= plen_ff;
      stat.sel_ok = 32'(req_entry_select) < 32'(used_ff) &&
                    32'(req_entry_select) < TABLE_ENTRIES;
      stat.rd_last = pos_ff + LB'(1) >= tlen_ff;
   end

   always_comb begin
      plen_in = plen_ff;
      trunc_in = trunc_ff;
      used_in = used_ff;
      if (ctrl.append) begin
         if (32'(plen_ff) < MAX_WORD_LEN) plen_in = plen_ff + LB'(1);
         else trunc_in = 1'b1;
      end
      if (ctrl.clear_pending) plen_in = '0;
      if (ctrl.new_entry) used_in = used_ff + UB'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         used_ff <= '0;
         trunc_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         plen_ff <= plen_in;
         used_ff <= used_in;
         trunc_ff <= trunc_in;
         rsp_valid <= ctrl.emit_hit | ctrl.emit_new | ctrl.emit_drop |
                      ctrl.emit_char | ctrl.emit_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.append && 32'(plen_ff) < MAX_WORD_LEN) pend_mem[plen_ff[PB-1:0]] <= fold;
      if (ctrl.copy_char) char_mem[{eidx, pidx}] <= pend_mem[pidx];
      if (ctrl.new_entry) begin
         len_mem[eidx] <= plen_ff;
         cnt_mem[eidx] <= COUNT_BITS'(1);
      end
      if (ctrl.count_write) cnt_mem[eidx] <= cinc;
      if (ctrl.rd_len) begin
         tlen_ff <= len_mem[sel_ff];
         tcnt_ff <= cnt_mem[sel_ff];
      end
      if (ctrl.rd_slen) tlen_ff <= len_mem[eidx];
      if (ctrl.rd_schar) begin
         tchar_ff <= char_mem[{eidx, pidx}];
         tcnt_ff <= cnt_mem[eidx];
      end
      if (ctrl.rd_char) tchar_ff <= char_mem[{sel_ff, pidx}];
      if (ctrl.load_sel) sel_ff <= req_entry_select[EB-1:0];
      if (ctrl.clr_entry) ent_ff <= '0;
      else if (ctrl.inc_entry) ent_ff <= ent_ff + UB'(1);
      if (ctrl.clr_pos) pos_ff <= '0;
      else if (ctrl.inc_pos) pos_ff <= pos_ff + LB'(1);
   end

   always_ff @(posedge clock) begin
      rsp_truncated_seen <= trunc_in;
      rsp_entries_used <= 7'(used_in);
      rsp_is_new_word <= ctrl.emit_new;
      rsp_word_dropped <= ctrl.emit_drop;
      if (ctrl.emit_char) begin
         rsp_result_kind <= KIND_READ;
         rsp_entry_valid <= 1'b1;
         rsp_entry_index <= 6'(sel_ff);
         rsp_entry_count <= 24'(tcnt_ff);
         rsp_out_char <= tchar_ff;
         rsp_char_position <= 4'(pos_ff);
         rsp_last <= stat.rd_last;
      end else if (ctrl.emit_empty) begin
         rsp_result_kind <= KIND_READ;
         rsp_entry_valid <= 1'b0;
         rsp_entry_index <= req_entry_select;
         rsp_entry_count <= '0;
         rsp_out_char <= '0;
         rsp_char_position <= '0;
         rsp_last <= 1'b1;
      end else if (ctrl.emit_drop) begin
         rsp_result_kind <= KIND_COUNT;
         rsp_entry_valid <= 1'b0;
         rsp_entry_index <= '0;
         rsp_entry_count <= '0;
         rsp_out_char <= '0;
         rsp_char_position <= '0;
         rsp_last <= 1'b1;
      end else begin
         rsp_result_kind <= KIND_COUNT;
         rsp_entry_valid <= 1'b1;
         rsp_entry_index <= 6'(ent_ff);
         rsp_entry_count <= ctrl.emit_new ? 24'd1 : 24'(cinc);
         rsp_out_char <= '0;
         rsp_char_position <= '0;
         rsp_last <= 1'b1;
      end
   end
endmodule
